@@ src/bptc_pkg.sv @@
// Shared types and constants for the barometric compensation block.
// No dependencies; imported by the front, back and top-level modules.

package bptc_pkg;

  localparam int RawW   = 24;
  localparam int CoeffW = 16;
  localparam int DtW    = RawW + 1;
  localparam int TempW  = 19;
  localparam int PressW = 32;
  localparam int IdxW   = 3;

  localparam int TempBase  = 2000;
  localparam int DeepCold  = -1500;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_SENS       = 3'd0;
  localparam logic [IdxW-1:0] REG_OFFSET     = 3'd1;
  localparam logic [IdxW-1:0] REG_SENS_TEMP  = 3'd2;
  localparam logic [IdxW-1:0] REG_OFFSET_TMP = 3'd3;
  localparam logic [IdxW-1:0] REG_REF_TEMP   = 3'd4;
  localparam logic [IdxW-1:0] REG_TEMP_SLOPE = 3'd5;

  localparam logic [CoeffW-1:0] C1_RST = 16'd40127;
  localparam logic [CoeffW-1:0] C2_RST = 16'd36924;
  localparam logic [CoeffW-1:0] C3_RST = 16'd23317;
  localparam logic [CoeffW-1:0] C4_RST = 16'd23282;
  localparam logic [CoeffW-1:0] C5_RST = 16'd33464;
  localparam logic [CoeffW-1:0] C6_RST = 16'd28312;

  typedef struct packed {
    logic [CoeffW-1:0] c1;
    logic [CoeffW-1:0] c2;
    logic [CoeffW-1:0] c3;
    logic [CoeffW-1:0] c4;
    logic [CoeffW-1:0] c5;
    logic [CoeffW-1:0] c6;
  } bptc_coeff_t;

  // one queued request: raw pressure plus the temperature difference dT
  typedef struct packed {
    logic [RawW-1:0]       d1;
    logic signed [DtW-1:0] dt;
  } bptc_item_t;

endpackage

@@ src/bptc_front.sv @@
// Front end: accepts raw conversion pairs, forms dT and queues the request.
// Depends on bptc_pkg for the item and coefficient types.

module bptc_front import bptc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RawW-1:0]   in_raw_pressure,
  input  logic [RawW-1:0]   in_raw_temperature,
  input  bptc_coeff_t       coeff,
  output logic              q_valid,
  output bptc_item_t        q_item,
  input  logic              q_pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  bptc_item_t      mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push;
  bptc_item_t      new_item;

  assign in_stall = (count_r == CntW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // dT = D2 - C5 * 256
  always_comb begin
    new_item.d1 = in_raw_pressure;
    new_item.dt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, coeff.c5, 8'b0});
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("request queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("pop from empty request queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + CntW'($past(push)) - CntW'($past(q_pop)))
    else $error("request queue count lost track of push and pop");

endmodule

@@ src/bptc_back.sv @@
// Back end: eight-stage compensation datapath with second-order correction.
// Depends on bptc_pkg; pops requests queued by bptc_front.

module bptc_back import bptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bptc_coeff_t              coeff,
  input  logic                     q_valid,
  input  bptc_item_t               q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TempW-1:0]  out_temperature_centideg,
  output logic signed [PressW-1:0] out_pressure_out
);

  logic adv;
  logic [7:1] vld_r, vld_nxt;

  // stage 1: products of dT
  logic [RawW-1:0]     d1_1_r;
  logic signed [41:0]  m_t_r, m_t_nxt;
  logic signed [41:0]  m_off_r, m_off_nxt;
  logic signed [41:0]  m_sens_r, m_sens_nxt;
  logic signed [49:0]  m_sq_r, m_sq_nxt;
  // stage 2: first-order terms
  logic [RawW-1:0]     d1_2_r;
  logic signed [19:0]  temp_2_r, temp_2_nxt;
  logic signed [35:0]  off_2_r, off_2_nxt;
  logic signed [34:0]  sens_2_r, sens_2_nxt;
  logic [17:0]         t2_2_r, t2_2_nxt;
  // stage 3: classify and square the temperature offsets
  logic [RawW-1:0]     d1_3_r;
  logic signed [19:0]  temp_3_r;
  logic signed [35:0]  off_3_r;
  logic signed [34:0]  sens_3_r;
  logic [17:0]         t2_3_r;
  logic                cold_3_r, cold_3_nxt;
  logic                deep_3_r, deep_3_nxt;
  logic [34:0]         sq_3_r, sq_3_nxt;
  logic [34:0]         sqd_3_r, sqd_3_nxt;
  logic signed [18:0]  a_dev, b_dev;
  logic signed [37:0]  a_sq, b_sq;
  // stage 4: second-order corrections
  logic [RawW-1:0]     d1_4_r;
  logic signed [35:0]  off_4_r;
  logic signed [34:0]  sens_4_r;
  logic signed [20:0]  temp_4_r, temp_4_nxt;
  logic [39:0]         off2_4_r, off2_4_nxt;
  logic [39:0]         sens2_4_r, sens2_4_nxt;
  logic                cold_4_r;
  logic [36:0]         five_sq;
  logic [37:0]         seven_sqd;
  logic [38:0]         eleven_sqd;
  // stage 5: corrected offset and sensitivity
  logic [RawW-1:0]     d1_5_r;
  logic signed [20:0]  temp_5_r;
  logic signed [40:0]  off_5_r, off_5_nxt;
  logic signed [40:0]  sens_5_r, sens_5_nxt;
  // stage 6: split D1 * SENS into two partial products
  logic signed [20:0]  temp_6_r;
  logic signed [40:0]  off_6_r;
  logic [44:0]         p_lo_r, p_lo_nxt;
  logic signed [44:0]  p_hi_r, p_hi_nxt;
  // stage 7: (D1 * SENS) >> 21
  logic signed [20:0]  temp_7_r;
  logic signed [40:0]  off_7_r;
  logic signed [45:0]  sc_7_r, sc_7_nxt;
  // stage 8: output register
  logic                     out_valid_r;
  logic signed [TempW-1:0]  temp_out_r;
  logic signed [PressW-1:0] press_out_r, press_nxt;
  logic signed [46:0]       diff;

  // advance the whole pipeline whenever the output slot is free or taken
  assign adv       = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && adv;
  assign out_valid = out_valid_r;
  assign out_temperature_centideg = temp_out_r;
  assign out_pressure_out         = press_out_r;

  always_comb begin
    vld_nxt = {vld_r[6:1], q_pop};
  end

  always_comb begin
    m_t_nxt    = q_item.dt * $signed({1'b0, coeff.c6});
    m_off_nxt  = q_item.dt * $signed({1'b0, coeff.c4});
    m_sens_nxt = q_item.dt * $signed({1'b0, coeff.c3});
    m_sq_nxt   = q_item.dt * q_item.dt;
  end

  always_comb begin
    temp_2_nxt = 20'(m_t_r >>> 23) + 20'sd2000;
    off_2_nxt  = $signed({4'b0, coeff.c2, 16'b0}) + 36'(m_off_r >>> 7);
    sens_2_nxt = $signed({4'b0, coeff.c1, 15'b0}) + 35'(m_sens_r >>> 8);
    t2_2_nxt   = 18'(m_sq_r >>> 31);
  end

  always_comb begin
    a_dev      = 19'(temp_2_r - 20'(TempBase));
    b_dev      = 19'(temp_2_r - 20'(DeepCold));
    a_sq       = a_dev * a_dev;
    b_sq       = b_dev * b_dev;
    sq_3_nxt   = a_sq[34:0];
    sqd_3_nxt  = b_sq[34:0];
    cold_3_nxt = temp_2_r < 20'(TempBase);
    deep_3_nxt = temp_2_r < 20'(DeepCold);
  end

  always_comb begin
    five_sq    = {sq_3_r, 2'b0} + {2'b0, sq_3_r};
    seven_sqd  = {sqd_3_r, 3'b0} - {3'b0, sqd_3_r};
    eleven_sqd = {1'b0, sqd_3_r, 3'b0} + {3'b0, sqd_3_r, 1'b0} + {4'b0, sqd_3_r};
    off2_4_nxt  = '0;
    sens2_4_nxt = '0;
    temp_4_nxt  = 21'(temp_3_r);
    if (cold_3_r) begin
      off2_4_nxt  = 40'(five_sq >> 1);
      sens2_4_nxt = 40'(five_sq >> 2);
      temp_4_nxt  = 21'(temp_3_r) - $signed({3'b0, t2_3_r});
      if (deep_3_r) begin
        off2_4_nxt  = 40'(five_sq >> 1) + 40'(seven_sqd);
        sens2_4_nxt = 40'(five_sq >> 2) + 40'(eleven_sqd >> 1);
      end
    end
  end

  always_comb begin
    off_5_nxt  = 41'(off_4_r) - $signed({1'b0, off2_4_r});
    sens_5_nxt = 41'(sens_4_r) - $signed({1'b0, sens2_4_r});
  end

  always_comb begin
    p_lo_nxt = d1_5_r * sens_5_r[20:0];
    p_hi_nxt = $signed({1'b0, d1_5_r}) * $signed(sens_5_r[40:21]);
  end

  // the low partial product is non-negative, so the floor shift splits cleanly
  always_comb begin
    sc_7_nxt = 46'(p_hi_r) + $signed({22'b0, p_lo_r[44:21]});
  end

  // the shifted difference always lies inside the signed 32-bit range
  always_comb begin
    diff      = 47'(sc_7_r) - 47'(off_7_r);
    press_nxt = 32'(diff >>> 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_1_r      <= q_item.d1;
      m_t_r       <= m_t_nxt;
      m_off_r     <= m_off_nxt;
      m_sens_r    <= m_sens_nxt;
      m_sq_r      <= m_sq_nxt;

      d1_2_r      <= d1_1_r;
      temp_2_r    <= temp_2_nxt;
      off_2_r     <= off_2_nxt;
      sens_2_r    <= sens_2_nxt;
      t2_2_r      <= t2_2_nxt;

      d1_3_r      <= d1_2_r;
      temp_3_r    <= temp_2_r;
      off_3_r     <= off_2_r;
      sens_3_r    <= sens_2_r;
      t2_3_r      <= t2_2_r;
      cold_3_r    <= cold_3_nxt;
      deep_3_r    <= deep_3_nxt;
      sq_3_r      <= sq_3_nxt;
      sqd_3_r     <= sqd_3_nxt;

      d1_4_r      <= d1_3_r;
      off_4_r     <= off_3_r;
      sens_4_r    <= sens_3_r;
      temp_4_r    <= temp_4_nxt;
      off2_4_r    <= off2_4_nxt;
      sens2_4_r   <= sens2_4_nxt;
      cold_4_r    <= cold_3_r;

      d1_5_r      <= d1_4_r;
      temp_5_r    <= temp_4_r;
      off_5_r     <= off_5_nxt;
      sens_5_r    <= sens_5_nxt;

      temp_6_r    <= temp_5_r;
      off_6_r     <= off_5_r;
      p_lo_r      <= p_lo_nxt;
      p_hi_r      <= p_hi_nxt;

      temp_7_r    <= temp_6_r;
      off_7_r     <= off_6_r;
      sc_7_r      <= sc_7_nxt;

      temp_out_r  <= temp_7_r[TempW-1:0];
      press_out_r <= press_nxt;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !q_pop)
    else $error("request popped while the output is stalled");

  a_deep_is_cold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && deep_3_r) |-> cold_3_r)
    else $error("deep-cold item not classified as cold");

  a_warm_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !cold_4_r) |-> (off2_4_r == '0 && sens2_4_r == '0))
    else $error("second-order correction applied to a warm item");

endmodule

@@ src/baro_pressure_temp_compensation_unit.sv @@
// Throughput: one request per cycle unless out_stall holds a valid result; the
// eight-stage datapath is fully pipelined and the request queue (QUEUE_DEPTH
// entries) lets input and output stall apart.
// Reset (rst_n low, synchronous) empties queue and pipeline and restores the
// six calibration words to their defaults.
// Top level: calibration registers, bptc_front and bptc_back; uses bptc_pkg.

module baro_pressure_temp_compensation_unit import bptc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RawW-1:0]          in_raw_pressure,
  input  logic [RawW-1:0]          in_raw_temperature,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TempW-1:0]  out_temperature_centideg,
  output logic signed [PressW-1:0] out_pressure_out,
  input  logic                     cfg_we,
  input  logic [IdxW-1:0]          cfg_index,
  input  logic [CoeffW-1:0]        cfg_data
);

  bptc_coeff_t coeff_r, coeff_nxt;
  logic        q_valid;
  bptc_item_t  q_item;
  logic        q_pop;

  // drop writes to indexes past the last register
  always_comb begin
    coeff_nxt = coeff_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SENS:       coeff_nxt.c1 = cfg_data;
        REG_OFFSET:     coeff_nxt.c2 = cfg_data;
        REG_SENS_TEMP:  coeff_nxt.c3 = cfg_data;
        REG_OFFSET_TMP: coeff_nxt.c4 = cfg_data;
        REG_REF_TEMP:   coeff_nxt.c5 = cfg_data;
        REG_TEMP_SLOPE: coeff_nxt.c6 = cfg_data;
        default:        coeff_nxt = coeff_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '{c1: C1_RST, c2: C2_RST, c3: C3_RST,
                   c4: C4_RST, c5: C5_RST, c6: C6_RST};
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  bptc_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .coeff              (coeff_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  bptc_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .coeff                    (coeff_r),
    .q_valid                  (q_valid),
    .q_item                   (q_item),
    .q_pop                    (q_pop),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_temperature_centideg (out_temperature_centideg),
    .out_pressure_out         (out_pressure_out)
  );

endmodule
